### rtl/brs_pkg.sv
// Shared types, codes and helpers for the bus request sequencer.
package brs_pkg;

  localparam int unsigned CountWidth  = 16;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 2;

  typedef logic [CountWidth-1:0]  count_t;
  typedef logic [CfgWidth-1:0]    cfg_data_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgInitRetry    = 2'd0;
  localparam cfg_idx_t CfgClockPeriod  = 2'd1;
  localparam cfg_idx_t CfgSensorPeriod = 2'd2;

  localparam cfg_data_t MsReset = 16'd1000;

  // Request / command codes
  typedef logic [2:0] cmd_t;
  localparam cmd_t CmdNone      = 3'd0;
  localparam cmd_t CmdClockRd   = 3'd1;
  localparam cmd_t CmdClockWr   = 3'd2;
  localparam cmd_t CmdSensInit  = 3'd3;
  localparam cmd_t CmdSensRd    = 3'd4;
  localparam cmd_t CmdMemtest   = 3'd5;

  // Driver status codes
  typedef logic [1:0] drv_status_t;
  localparam drv_status_t StOk   = 2'd0;
  localparam drv_status_t StBusy = 2'd1;
  localparam drv_status_t StErr  = 2'd2;
  localparam drv_status_t StBad  = 2'd3;

  // Driver operation codes
  typedef logic [3:0] op_t;
  localparam op_t OpNone         = 4'd0;
  localparam op_t OpClockRdStart = 4'd1;
  localparam op_t OpClockRdPoll  = 4'd2;
  localparam op_t OpClockWrStart = 4'd3;
  localparam op_t OpClockWrPoll  = 4'd4;
  localparam op_t OpPowerOn      = 4'd5;
  localparam op_t OpCmdPoll      = 4'd6;
  localparam op_t OpContMode     = 4'd7;
  localparam op_t OpSensRdStart  = 4'd8;
  localparam op_t OpSensRdPoll   = 4'd9;
  localparam op_t OpMemtestPoll  = 4'd10;

  typedef logic [1:0] upd_t;
  localparam upd_t UpdNone   = 2'd0;
  localparam upd_t UpdClock  = 2'd1;
  localparam upd_t UpdSensor = 2'd2;

  typedef logic [1:0] phase_t;
  localparam phase_t Phase0 = 2'd0;
  localparam phase_t Phase1 = 2'd1;
  localparam phase_t Phase2 = 2'd2;
  localparam phase_t Phase3 = 2'd3;

  typedef struct packed {
    logic        kind;
    cmd_t        command;
    drv_status_t driver_status;
    logic        ms_elapsed;
    logic        memtest_running;
    logic        memtest_failed;
  } item_t;

  typedef struct packed {
    op_t         next_operation;
    upd_t        updated;
    logic        done_valid;
    cmd_t        done_command;
    drv_status_t done_status;
    logic        done_internal;
  } result_t;

  typedef struct packed {
    cfg_data_t init_retry_ms;
    cfg_data_t clock_period_ms;
    cfg_data_t sensor_period_ms;
  } reloads_t;

  function automatic op_t first_op(cmd_t cmd);
    op_t op;
    case (cmd)
      CmdClockRd:  op = OpClockRdStart;
      CmdClockWr:  op = OpClockWrStart;
      CmdSensInit: op = OpPowerOn;
      CmdSensRd:   op = OpSensRdStart;
      default:     op = OpMemtestPoll;
    endcase
    return op;
  endfunction

endpackage

### rtl/brs_intf.sv
// Channel interfaces: request/poll input, result output, register write.
interface brs_in_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  brs_pkg::cmd_t        command;
  brs_pkg::drv_status_t driver_status;
  logic                 ms_elapsed;
  logic                 memtest_running;
  logic                 memtest_failed;

  modport source (output valid, kind, command, driver_status, ms_elapsed,
                  memtest_running, memtest_failed, input ready);
  modport sink   (input valid, kind, command, driver_status, ms_elapsed,
                  memtest_running, memtest_failed, output ready);
endinterface

interface brs_out_if;
  logic                 valid;
  logic                 ready;
  brs_pkg::op_t         next_operation;
  brs_pkg::upd_t        updated;
  logic                 done_valid;
  brs_pkg::cmd_t        done_command;
  brs_pkg::drv_status_t done_status;
  logic                 done_internal;

  modport source (output valid, next_operation, updated, done_valid, done_command,
                  done_status, done_internal, input ready);
  modport sink   (input valid, next_operation, updated, done_valid, done_command,
                  done_status, done_internal, output ready);
endinterface

interface brs_cfg_if;
  logic                 valid;
  logic                 ready;
  brs_pkg::cfg_idx_t    index;
  brs_pkg::cfg_data_t   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/brs_cfg_regs.sv
// Reload registers for the three millisecond countdowns.
module brs_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  brs_cfg_if.sink            cfg_i,
  output brs_pkg::reloads_t  reloads_o
);

  brs_pkg::reloads_t reloads_q, reloads_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    reloads_d = reloads_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        brs_pkg::CfgInitRetry:    reloads_d.init_retry_ms    = cfg_i.data;
        brs_pkg::CfgClockPeriod:  reloads_d.clock_period_ms  = cfg_i.data;
        brs_pkg::CfgSensorPeriod: reloads_d.sensor_period_ms = cfg_i.data;
        default:                  reloads_d = reloads_q;  // unused index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reloads_q.init_retry_ms    <= brs_pkg::MsReset;
      reloads_q.clock_period_ms  <= brs_pkg::MsReset;
      reloads_q.sensor_period_ms <= brs_pkg::MsReset;
    end else begin
      reloads_q <= reloads_d;
    end
  end

  assign reloads_o = reloads_q;

endmodule

### rtl/brs_engine.sv
// Sequencer state, countdowns and the per-transaction step logic.
module brs_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  brs_pkg::item_t     item_i,
  input  brs_pkg::reloads_t  reloads_i,
  output brs_pkg::result_t   result_o
);

  brs_pkg::cmd_t   act_cmd_q, act_cmd_d;
  brs_pkg::phase_t act_phase_q, act_phase_d;
  logic            act_int_q, act_int_d;
  brs_pkg::cmd_t   pend_cmd_q, pend_cmd_d;
  logic            pend_int_q, pend_int_d;
  logic            sens_rdy_q, sens_rdy_d;
  brs_pkg::count_t init_cnt_q, init_cnt_d;
  brs_pkg::count_t clk_cnt_q, clk_cnt_d;
  brs_pkg::count_t sens_cnt_q, sens_cnt_d;

  always_comb begin
    brs_pkg::drv_status_t st;
    brs_pkg::drv_status_t fin_st;
    brs_pkg::op_t         first;
    logic                 fin;

    act_cmd_d   = act_cmd_q;
    act_phase_d = act_phase_q;
    act_int_d   = act_int_q;
    pend_cmd_d  = pend_cmd_q;
    pend_int_d  = pend_int_q;
    sens_rdy_d  = sens_rdy_q;
    init_cnt_d  = init_cnt_q;
    clk_cnt_d   = clk_cnt_q;
    sens_cnt_d  = sens_cnt_q;
    result_o    = '0;
    fin         = 1'b0;
    fin_st      = brs_pkg::StOk;
    st          = (item_i.driver_status == brs_pkg::StBad) ? brs_pkg::StErr
                                                           : item_i.driver_status;
    first       = brs_pkg::first_op(act_cmd_q);

    if (item_i.kind) begin
      // Software request: overwrite pending slot, codes 6/7 dropped
      if (item_i.command <= brs_pkg::CmdMemtest) begin
        pend_cmd_d = item_i.command;
        pend_int_d = 1'b0;
      end
    end else begin
      unique case (act_cmd_q)
        brs_pkg::CmdClockRd, brs_pkg::CmdClockWr, brs_pkg::CmdSensRd: begin
          if (act_phase_q == brs_pkg::Phase0) begin
            if (st == brs_pkg::StOk) begin
              result_o.next_operation = first + 4'd1;
              act_phase_d = brs_pkg::Phase1;
            end else begin
              fin = 1'b1; fin_st = st;
            end
          end else if (st == brs_pkg::StBusy) begin
            result_o.next_operation = first + 4'd1;
          end else begin
            if (st == brs_pkg::StOk && act_cmd_q == brs_pkg::CmdClockRd)
              result_o.updated = brs_pkg::UpdClock;
            if (st == brs_pkg::StOk && act_cmd_q == brs_pkg::CmdSensRd)
              result_o.updated = brs_pkg::UpdSensor;
            fin = 1'b1; fin_st = st;
          end
        end
        brs_pkg::CmdSensInit: begin
          unique case (act_phase_q)
            brs_pkg::Phase0: begin
              if (st == brs_pkg::StOk) begin
                result_o.next_operation = brs_pkg::OpCmdPoll;
                act_phase_d = brs_pkg::Phase1;
              end else begin
                fin = 1'b1; fin_st = st;
              end
            end
            brs_pkg::Phase1: begin
              if (st == brs_pkg::StOk) begin
                result_o.next_operation = brs_pkg::OpContMode;
                act_phase_d = brs_pkg::Phase2;
              end else if (st == brs_pkg::StBusy) begin
                result_o.next_operation = brs_pkg::OpCmdPoll;
              end else begin
                fin = 1'b1; fin_st = st;
              end
            end
            brs_pkg::Phase2: begin
              if (st == brs_pkg::StOk) begin
                result_o.next_operation = brs_pkg::OpCmdPoll;
                act_phase_d = brs_pkg::Phase3;
              end else begin
                fin = 1'b1; fin_st = st;
              end
            end
            brs_pkg::Phase3: begin
              if (st == brs_pkg::StBusy) begin
                result_o.next_operation = brs_pkg::OpCmdPoll;
              end else begin
                fin = 1'b1; fin_st = st;
              end
            end
          endcase
        end
        brs_pkg::CmdMemtest: begin
          if (item_i.memtest_running) begin
            result_o.next_operation = brs_pkg::OpMemtestPoll;
          end else begin
            fin = 1'b1;
            fin_st = item_i.memtest_failed ? brs_pkg::StErr : brs_pkg::StOk;
          end
        end
        brs_pkg::CmdNone: begin
          if (pend_cmd_q != brs_pkg::CmdNone && pend_cmd_q <= brs_pkg::CmdMemtest) begin
            // takeover: first operation named in this same step
            act_cmd_d   = pend_cmd_q;
            act_int_d   = pend_int_q;
            act_phase_d = brs_pkg::Phase0;
            pend_cmd_d  = brs_pkg::CmdNone;
            pend_int_d  = 1'b0;
            result_o.next_operation = brs_pkg::first_op(pend_cmd_q);
          end else if (!sens_rdy_q && init_cnt_q == '0) begin
            pend_cmd_d = brs_pkg::CmdSensInit;
            pend_int_d = 1'b1;
            init_cnt_d = brs_pkg::count_t'(reloads_i.init_retry_ms);
          end else if (clk_cnt_q == '0) begin
            pend_cmd_d = brs_pkg::CmdClockRd;
            pend_int_d = 1'b1;
            clk_cnt_d  = brs_pkg::count_t'(reloads_i.clock_period_ms);
          end else if (sens_cnt_q == '0) begin
            pend_cmd_d = brs_pkg::CmdSensRd;
            pend_int_d = 1'b1;
            sens_cnt_d = brs_pkg::count_t'(reloads_i.sensor_period_ms);
          end
        end
        default: begin
          act_cmd_d   = brs_pkg::CmdNone;
          act_phase_d = brs_pkg::Phase0;
          act_int_d   = 1'b0;
        end
      endcase

      if (fin) begin
        result_o.done_valid    = 1'b1;
        result_o.done_command  = act_cmd_q;
        result_o.done_status   = fin_st;
        result_o.done_internal = act_int_q;
        if (act_cmd_q == brs_pkg::CmdSensInit && act_int_q)
          sens_rdy_d = (fin_st == brs_pkg::StOk);
        act_cmd_d   = brs_pkg::CmdNone;
        act_phase_d = brs_pkg::Phase0;
        act_int_d   = 1'b0;
      end

      // ms tick applies after any reload
      if (item_i.ms_elapsed) begin
        if (init_cnt_d != '0) init_cnt_d = init_cnt_d - brs_pkg::count_t'(1);
        if (clk_cnt_d != '0)  clk_cnt_d  = clk_cnt_d - brs_pkg::count_t'(1);
        if (sens_cnt_d != '0) sens_cnt_d = sens_cnt_d - brs_pkg::count_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_cmd_q   <= brs_pkg::CmdNone;
      act_phase_q <= brs_pkg::Phase0;
      act_int_q   <= 1'b0;
      pend_cmd_q  <= brs_pkg::CmdNone;
      pend_int_q  <= 1'b0;
      sens_rdy_q  <= 1'b0;
      init_cnt_q  <= '0;
      clk_cnt_q   <= '0;
      sens_cnt_q  <= '0;
    end else if (step_i) begin
      act_cmd_q   <= act_cmd_d;
      act_phase_q <= act_phase_d;
      act_int_q   <= act_int_d;
      pend_cmd_q  <= pend_cmd_d;
      pend_int_q  <= pend_int_d;
      sens_rdy_q  <= sens_rdy_d;
      init_cnt_q  <= init_cnt_d;
      clk_cnt_q   <= clk_cnt_d;
      sens_cnt_q  <= sens_cnt_d;
    end
  end

endmodule

### rtl/bus_request_sequencer_unit.sv
// Top level of the bus request sequencer: input register, step logic, result register.
//
//  channel | dir | modport | carries
//  --------+-----+---------+-------------------------------------------------
//  in_i    | in  | sink    | request or poll transaction (kind, command, status..)
//  out_o   | out | source  | one result transaction per input transaction
//  cfg_i   | in  | sink    | register write: index 0..2, 16-bit reload value
//
// Cycles: one transaction per cycle sustained while out_o is taken. An
// accepted transaction is held in the input register, is stepped through
// the sequencer logic and lands in the result register, from which out_o
// presents it as valid until it is taken.
// Reset: asynchronous, active low; clears sequencer state, countdowns and
// valid flags; reloads come up at 1000 ms.
// Stalls: when out_o is not taken, the result register holds and the input
// register fills; in_i.ready drops only when both are occupied.
module bus_request_sequencer_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  brs_in_if.sink   in_i,
  brs_out_if.source out_o,
  brs_cfg_if.sink  cfg_i
);

  // Input register stage
  logic              in_vld_q, in_vld_d;
  brs_pkg::item_t    item_q;
  // Result register stage
  logic              out_vld_q, out_vld_d;
  brs_pkg::result_t  res_q;
  brs_pkg::result_t  res_step;
  brs_pkg::reloads_t reloads;
  logic              advance;
  logic              in_take;

  // A held transaction moves on whenever the result slot is free or being drained.
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take)      in_vld_d = 1'b1;
    else if (advance) in_vld_d = 1'b0;

    out_vld_d = out_vld_q;
    if (advance)          out_vld_d = 1'b1;
    else if (out_o.ready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.kind            <= in_i.kind;
      item_q.command         <= in_i.command;
      item_q.driver_status   <= in_i.driver_status;
      item_q.ms_elapsed      <= in_i.ms_elapsed;
      item_q.memtest_running <= in_i.memtest_running;
      item_q.memtest_failed  <= in_i.memtest_failed;
    end
    if (advance) res_q <= res_step;
  end

  brs_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .reloads_o (reloads)
  );

  // State commits only when the result is actually registered
  brs_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (item_q),
    .reloads_i (reloads),
    .result_o  (res_step)
  );

  assign out_o.valid          = out_vld_q;
  assign out_o.next_operation = res_q.next_operation;
  assign out_o.updated        = res_q.updated;
  assign out_o.done_valid     = res_q.done_valid;
  assign out_o.done_command   = res_q.done_command;
  assign out_o.done_status    = res_q.done_status;
  assign out_o.done_internal  = res_q.done_internal;

  // A finished command never names another driver operation in the same step.
  a_done_no_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.done_valid |-> out_o.next_operation == brs_pkg::OpNone)
    else $error("operation named alongside completion");

  // A value update only comes with a successful completion.
  a_upd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.updated != brs_pkg::UpdNone |->
      out_o.done_valid && out_o.done_status == brs_pkg::StOk)
    else $error("update without successful completion");

  // Completion fields are zero when nothing finished.
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.done_valid |->
      out_o.done_command == brs_pkg::CmdNone && out_o.done_status == brs_pkg::StOk &&
      !out_o.done_internal)
    else $error("completion fields set without completion");

  // A stalled transaction in the input register stays put.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(item_q))
    else $error("input register lost a waiting transaction");

endmodule
